/* sv/nls_pkg.sv */
package nls_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_PREFIX = 3'b010,
        MODE_DIGITS = 3'b100
    } scan_mode_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    localparam logic [7:0] CH_UNDERSCORE = 8'd95;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_SEVEN      = 8'h37;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UP_A       = 8'h41;
    localparam logic [7:0] CH_UP_F       = 8'h46;
    localparam logic [7:0] CH_LO_A       = 8'h61;
    localparam logic [7:0] CH_LO_F       = 8'h66;
    localparam logic [7:0] CH_LO_B       = 8'h62;
    localparam logic [7:0] CH_UP_B       = 8'h42;
    localparam logic [7:0] CH_LO_X       = 8'h78;
    localparam logic [7:0] CH_UP_X       = 8'h58;
    localparam logic [7:0] CH_LO_L       = 8'h6c;
    localparam logic [7:0] CH_UP_L       = 8'h4c;

    typedef struct packed {
        logic [7:0] ch;
        logic       begin_req;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic       consumed;
        logic       done_res;
        radix_t     radix_code;
        logic [7:0] token_length;
        logic       error;
    } out_word_t;

    typedef struct packed {
        scan_mode_t mode;
        radix_t     radix;
        logic [7:0] length;
    } scan_state_t;

    function automatic logic in_class(radix_t radix, logic [7:0] c);
        logic dec;
        logic cls;
        dec = (c >= CH_ZERO) && (c <= CH_NINE);
        case (radix)
            RADIX_BIN: cls = (c == CH_ZERO) || (c == CH_ONE);
            RADIX_OCT: cls = (c >= CH_ZERO) && (c <= CH_SEVEN);
            RADIX_HEX: cls = dec || ((c >= CH_UP_A) && (c <= CH_UP_F))
                             || ((c >= CH_LO_A) && (c <= CH_LO_F));
            default:   cls = dec;
        endcase
        return cls || (c == CH_UNDERSCORE);
    endfunction

endpackage

/* sv/nls_if.sv */
interface nls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       begin_req;
    logic       end_of_input;

    modport source (output valid, output ch, output begin_req, output end_of_input,
                    input ready);
    modport sink   (input valid, input ch, input begin_req, input end_of_input,
                    output ready);
endinterface

interface nls_out_if;
    logic       valid;
    logic       ready;
    logic       consumed;
    logic       done_res;
    logic [1:0] radix_code;
    logic [7:0] token_length;
    logic       error;

    modport source (output valid, output consumed, output done_res, output radix_code,
                    output token_length, output error, input ready);
    modport sink   (input valid, input consumed, input done_res, input radix_code,
                    input token_length, input error, output ready);
endinterface

/* sv/nls_step.sv */
module nls_step
    import nls_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 255
)
(
    input  in_word_t    word,
    input  scan_state_t cur,
    output scan_state_t nxt,
    output out_word_t   res
);

    localparam logic [7:0] LEN_CAP =
        (MAX_TOKEN_LENGTH < 255) ? 8'(MAX_TOKEN_LENGTH) : 8'd255;

    logic [7:0] bumped;
    radix_t     sel;
    logic       sel_ok;

    assign bumped = (cur.length < LEN_CAP) ? cur.length + 8'd1 : cur.length;

    always_comb
    begin
        sel    = RADIX_DEC;
        sel_ok = 1'b1;
        if (word.ch == CH_LO_B || word.ch == CH_UP_B)
            sel = RADIX_BIN;
        else if (word.ch == CH_LO_X || word.ch == CH_UP_X)
            sel = RADIX_HEX;
        else if (word.ch >= CH_ZERO && word.ch <= CH_SEVEN)
            sel = RADIX_OCT;
        else
            sel_ok = 1'b0;
    end

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (cur.mode) inside
            MODE_PREFIX, MODE_DIGITS:
            begin
                if (word.end_of_input)
                begin
                    res.done_res   = 1'b1;
                    res.error      = 1'b1;
                    res.radix_code = (cur.mode == MODE_DIGITS) ? cur.radix : RADIX_DEC;
                    nxt.mode       = MODE_IDLE;
                end
                else if (cur.mode == MODE_PREFIX)
                begin
                    if (sel_ok)
                    begin
                        res.consumed = 1'b1;
                        nxt.radix    = sel;
                        nxt.length   = bumped;
                        nxt.mode     = MODE_DIGITS;
                    end
                    else
                    begin
                        nxt.radix    = RADIX_DEC;
                        res.done_res = 1'b1;
                        nxt.mode     = MODE_IDLE;
                    end
                    res.radix_code = nxt.radix;
                end
                else
                begin
                    if (in_class(cur.radix, word.ch))
                    begin
                        res.consumed = 1'b1;
                        nxt.length   = bumped;
                    end
                    else if (word.ch == CH_LO_L || word.ch == CH_UP_L)
                    begin
                        res.consumed = 1'b1;
                        res.done_res = 1'b1;
                        nxt.length   = bumped;
                        nxt.mode     = MODE_IDLE;
                    end
                    else
                    begin
                        res.done_res = 1'b1;
                        nxt.mode     = MODE_IDLE;
                    end
                    res.radix_code = cur.radix;
                end
                res.token_length = nxt.length;
            end
            default:
            begin
                nxt.mode = MODE_IDLE;
                if (word.begin_req && !word.end_of_input)
                begin
                    res.consumed     = 1'b1;
                    nxt.radix        = RADIX_DEC;
                    nxt.length       = 8'd1;
                    nxt.mode         = (word.ch == CH_ZERO) ? MODE_PREFIX : MODE_DIGITS;
                    res.token_length = 8'd1;
                end
            end
        endcase
    end

endmodule

/* sv/numeric_literal_scanner.sv */
// Scans a C-style numeric literal one character word at a time and returns one result
// word per input word: whether the character belongs to the token, whether the token is
// complete, its radix (0 decimal, 1 binary, 2 octal, 3 hex), the length so far
// (saturating at the smaller of MAX_TOKEN_LENGTH and 255) and an error flag for end of
// input inside a token. A character that ends a token without being consumed must be
// presented again. Each word passes an input register, the combinational scan logic and a
// result register, and a new word is taken every cycle unless dout.ready holds back a
// waiting result; the scan state feeds back through the combinational scan logic.
module numeric_literal_scanner
    import nls_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 255
)
(
    input  logic      clk,
    input  logic      rst_n,
    nls_in_if.sink    din,
    nls_out_if.source dout
);

    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    out_word_t   res_next;
    logic        advance;
    logic        take;

    assign advance  = in_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !in_valid_reg || advance;
    assign take     = din.valid && din.ready;

    nls_step #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_step (
        .word (in_word_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (din.ready)
            in_valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg.ch           <= din.ch;
            in_word_reg.begin_req    <= din.begin_req;
            in_word_reg.end_of_input <= din.end_of_input;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode   <= MODE_IDLE;
            state_reg.radix  <= RADIX_DEC;
            state_reg.length <= 8'd0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= res_next;
    end

    assign dout.valid        = out_valid_reg;
    assign dout.consumed     = out_word_reg.consumed;
    assign dout.done_res     = out_word_reg.done_res;
    assign dout.radix_code   = out_word_reg.radix_code;
    assign dout.token_length = out_word_reg.token_length;
    assign dout.error        = out_word_reg.error;

endmodule
